@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define AST_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tach_pkg.sv @@
// ----------------------------------------------------------------------------
// Tachometer package
// Shared constants, register codes and interface types of the tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

    // Sample ring.
    localparam int RING_DEPTH = 8;
    localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Shared divider.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Register indexes and reset values.
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_TEETH    = 1'b1;
    localparam logic [15:0] RST_INTERVAL = 16'd100;
    localparam logic [9:0]  RST_TEETH    = 10'd32;

    // Minutes conversion: 60 s times 1000 ms.
    localparam logic [15:0] RPM_SCALE = 16'd60000;

    // One classified item handed from front to back.
    typedef struct packed {
        logic        taken;
        logic [31:0] now_ms;
        logic [31:0] elapsed;
        logic [15:0] edges;
    } t_cmd;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

@@ hw/rtl/tach_front.sv @@
// ----------------------------------------------------------------------------
// Tachometer front
// Counts tooth edges and milliseconds and decides whether an item takes a sample.
// ----------------------------------------------------------------------------
module tach_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_tooth_edge,
    input  logic           i_ms_tick,
    output logic           o_in_stall,
    input  logic [15:0]    i_interval,
    input  logic           i_fifo_full,
    output logic           o_push,
    output tach_pkg::t_cmd o_cmd
);

    logic [15:0] r_edges;
    logic [31:0] r_now;
    logic [31:0] r_last;
    logic [15:0] n_edges;
    logic [31:0] n_now;
    logic [31:0] elapsed;
    logic        taken;

    assign o_in_stall = i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full;

    // Apply this item's edge and tick, then compare the elapsed time.
    always_comb begin
        n_edges = r_edges;
        if (i_tooth_edge && (r_edges != 16'hFFFF)) begin
            n_edges = r_edges + 16'd1;
        end
        n_now   = i_ms_tick ? (r_now + 32'd1) : r_now;
        elapsed = n_now - r_last;
        taken   = elapsed > {16'd0, i_interval};
    end

    assign o_cmd.taken   = taken;
    assign o_cmd.now_ms  = n_now;
    assign o_cmd.elapsed = elapsed;
    assign o_cmd.edges   = n_edges;

    // Counter state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges <= '0;
            r_now   <= '0;
            r_last  <= '0;
        end else if (o_push) begin
            r_now <= n_now;
            if (taken) begin
                r_edges <= '0;
                r_last  <= n_now;
            end else begin
                r_edges <= n_edges;
            end
        end
    end

endmodule

@@ hw/rtl/tach_fifo.sv @@
// ----------------------------------------------------------------------------
// Tachometer command queue
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tach_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tach_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tach_pkg::t_cmd o_head
);

    tach_pkg::t_cmd                   r_mem [tach_pkg::FIFO_DEPTH];
    logic [tach_pkg::FIFO_IDX_W-1:0]  r_wr;
    logic [tach_pkg::FIFO_IDX_W-1:0]  r_rd;
    logic [tach_pkg::FIFO_CNT_W-1:0]  r_cnt;

    localparam logic [tach_pkg::FIFO_IDX_W-1:0] LAST_IDX =
        tach_pkg::FIFO_IDX_W'(tach_pkg::FIFO_DEPTH - 1);
    localparam logic [tach_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        tach_pkg::FIFO_CNT_W'(tach_pkg::FIFO_DEPTH);

    assign o_full  = r_cnt == FULL_CNT;
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    // Storage needs no reset; the count tells which entries hold an item.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/tach_div.sv @@
// ----------------------------------------------------------------------------
// Tachometer divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tach_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tach_pkg::t_div_req i_req,
    output tach_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [tach_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [tach_pkg::DIV_NUM_W-1:0]    r_num;
    logic [tach_pkg::DIV_DEN_W-1:0]    r_den;
    logic [tach_pkg::DIV_DEN_W-1:0]    r_rem;
    logic [tach_pkg::DIV_DEN_W:0]      rem_sh;
    logic                              ge;

    // One shift-and-subtract step.
    always_comb begin
        rem_sh = {r_rem, r_num[tach_pkg::DIV_NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == tach_pkg::DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tach_pkg::DIV_CNT_W'(tach_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tach_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: the numerator shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[tach_pkg::DIV_NUM_W-2:0], ge};
            r_rem <= ge ? rem_sh[tach_pkg::DIV_DEN_W-1:0] - r_den
                        : rem_sh[tach_pkg::DIV_DEN_W-1:0];
        end
    end

endmodule

@@ hw/rtl/tach_back.sv @@
// ----------------------------------------------------------------------------
// Tachometer back
// Stores samples in the ring and sequences the weighted average computation.
// ----------------------------------------------------------------------------
module tach_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  tach_pkg::t_cmd     i_head,
    output logic               o_pop,
    input  logic [9:0]         i_teeth,
    output tach_pkg::t_div_req o_div_req,
    input  tach_pkg::t_div_rsp i_div_rsp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_rpm_q8,
    output logic               o_sample_taken
);

    localparam int IW = tach_pkg::RING_IDX_W;
    localparam logic [IW-1:0] LAST_K = IW'(tach_pkg::RING_DEPTH - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ENT  = 4'd1;
    localparam logic [3:0] S_RDIV = 4'd2;
    localparam logic [3:0] S_WGT  = 4'd3;
    localparam logic [3:0] S_WDIV = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_AVG  = 4'd7;
    localparam logic [3:0] S_ADIV = 4'd8;
    localparam logic [3:0] S_SCL  = 4'd9;
    localparam logic [3:0] S_SST  = 4'd10;
    localparam logic [3:0] S_SDIV = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]    r_state;
    logic          r_valid [tach_pkg::RING_DEPTH];
    logic [31:0]   r_time  [tach_pkg::RING_DEPTH];
    logic [31:0]   r_intv  [tach_pkg::RING_DEPTH];
    logic [15:0]   r_edges [tach_pkg::RING_DEPTH];
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_k;
    logic [31:0]   r_now;
    logic [31:0]   r_rate;
    logic [15:0]   r_w;
    logic [47:0]   r_prod;
    logic [31:0]   r_sum_w;
    logic [63:0]   r_sum_wr;
    logic [31:0]   r_avg;
    logic [47:0]   r_scaled;
    logic [31:0]   r_rpm;
    logic          r_taken;
    logic          r_div_start;
    logic [63:0]   r_div_num;
    logic [31:0]   r_div_den;
    logic [31:0]   age;
    logic [9:0]    teeth_eff;

    assign o_pop          = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid    = r_state == S_OUT;
    assign o_rpm_q8       = r_rpm;
    assign o_sample_taken = r_taken;
    assign o_div_req.start = r_div_start;
    assign o_div_req.num   = r_div_num;
    assign o_div_req.den   = r_div_den;

    assign age       = r_now - r_time[r_k];
    assign teeth_eff = (i_teeth == '0) ? 10'd1 : i_teeth;

    // Ring payload: written at the next slot when a sample is taken.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.taken) begin
            r_time[r_slot]  <= i_head.now_ms;
            r_intv[r_slot]  <= i_head.elapsed;
            r_edges[r_slot] <= i_head.edges;
        end
    end

    // Sequencer: walks the ring one entry at a time through the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_rpm       <= '0;
            r_div_start <= 1'b0;
            for (int i = 0; i < tach_pkg::RING_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_taken <= i_head.taken;
                        if (i_head.taken) begin
                            r_valid[r_slot] <= 1'b1;
                            r_slot   <= (r_slot == LAST_K) ? '0 : r_slot + 1'b1;
                            r_now    <= i_head.now_ms;
                            r_k      <= '0;
                            r_sum_w  <= '0;
                            r_sum_wr <= '0;
                            r_state  <= S_ENT;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                // Rate of one entry: edges in Q16.16 over the interval.
                S_ENT: begin
                    if (!r_valid[r_k]) begin
                        if (r_k == LAST_K) begin
                            r_state <= S_AVG;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else if (r_intv[r_k] == '0) begin
                        r_rate  <= '0;
                        r_state <= S_WGT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_num   <= {16'd0, r_edges[r_k], 16'd0};
                        r_div_den   <= r_intv[r_k];
                        r_state     <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (i_div_rsp.done) begin
                        r_rate  <= i_div_rsp.quo[31:0];
                        r_state <= S_WGT;
                    end
                end
                // Weight 1/(age+1) in Q0.16; the newest entry saturates.
                S_WGT: begin
                    if (age == '0) begin
                        r_w     <= 16'hFFFF;
                        r_state <= S_MUL;
                    end else if (age[31:16] != '0) begin
                        r_w     <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_num   <= 64'h1_0000;
                        r_div_den   <= {16'd0, age[15:0]} + 32'd1;
                        r_state     <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (i_div_rsp.done) begin
                        r_w     <= i_div_rsp.quo[15:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_w * r_rate;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum_w  <= r_sum_w + {16'd0, r_w};
                    r_sum_wr <= r_sum_wr + {16'd0, r_prod};
                    if (r_k == LAST_K) begin
                        r_state <= S_AVG;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_ENT;
                    end
                end
                // Weighted mean of the rates.
                S_AVG: begin
                    if (r_sum_w == '0) begin
                        r_avg   <= '0;
                        r_state <= S_SCL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_sum_wr;
                        r_div_den   <= r_sum_w;
                        r_state     <= S_ADIV;
                    end
                end
                S_ADIV: begin
                    if (i_div_rsp.done) begin
                        r_avg   <= i_div_rsp.quo[31:0];
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    r_scaled <= r_avg * tach_pkg::RPM_SCALE;
                    r_state  <= S_SST;
                end
                // Divide by teeth times 256 to reach Q24.8 RPM.
                S_SST: begin
                    r_div_start <= 1'b1;
                    r_div_num   <= {16'd0, r_scaled};
                    r_div_den   <= {14'd0, teeth_eff, 8'd0};
                    r_state     <= S_SDIV;
                end
                S_SDIV: begin
                    if (i_div_rsp.done) begin
                        r_rpm   <= (i_div_rsp.quo[63:32] != '0) ? 32'hFFFF_FFFF
                                                                : i_div_rsp.quo[31:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/wheel_tachometer_weighted_average.sv @@
// An item without a sample passes from the queue through the idle state to its result; one
// that takes a sample has each older ring entry use the shared 64-step divider twice, the
// newest once, and two more divisions follow.
// Throughput: the front takes an item per cycle until the two-entry queue fills.
// Reset clears the counters, the ring valid bits and the cached speed, and loads
// the sample interval with 100 ms and the tooth count with 32.
// ----------------------------------------------------------------------------
// Wheel tachometer with weighted average
// Counts gear-tooth edges, samples them at a set interval and reports RPM.
// ----------------------------------------------------------------------------
module wheel_tachometer_weighted_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_tooth_edge,
    input  logic        i_ms_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_rpm_q8,
    output logic        o_sample_taken,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]        r_interval;
    logic [9:0]         r_teeth;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    tach_pkg::t_cmd     cmd;
    tach_pkg::t_cmd     head;
    tach_pkg::t_div_req div_req;
    tach_pkg::t_div_rsp div_rsp;

    // Configuration registers.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tach_pkg::REG_TEETH) ? {22'd0, r_teeth}
                                                      : {16'd0, r_interval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= tach_pkg::RST_INTERVAL;
            r_teeth    <= tach_pkg::RST_TEETH;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tach_pkg::REG_INTERVAL) begin
                r_interval <= pwdata[15:0];
            end else begin
                r_teeth <= pwdata[9:0];
            end
        end
    end

    tach_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_tooth_edge (i_tooth_edge),
        .i_ms_tick    (i_ms_tick),
        .o_in_stall   (o_in_stall),
        .i_interval   (r_interval),
        .i_fifo_full  (full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    tach_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    tach_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tach_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_teeth        (r_teeth),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rpm_q8       (o_rpm_q8),
        .o_sample_taken (o_sample_taken)
    );

endmodule

@@ hw/rtl/tach_chk.sv @@
// ----------------------------------------------------------------------------
// Tachometer port checker
// Watches the top-level ports of the tachometer over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tach_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_rpm_q8,
    input logic        o_sample_taken,
    input logic        pready
);

    // No result comes out of reset.
    `AST_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A stalled result holds its value and flag.
    `AST_CHK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rpm_q8) && $stable(o_sample_taken), "stalled result changed")

    // The speed only changes on a result that took a sample.
    `AST_CHK(a_rpm_cached, i_clk, i_rst_n, !$stable(o_rpm_q8) |-> o_out_valid && o_sample_taken, "cached speed changed")

    // The input handshake is always known.
    `AST_CHK(a_hs_known, i_clk, i_rst_n, !$isunknown({i_in_valid, o_in_stall}), "handshake unknown")

    // The configuration port never waits.
    `AST_CHK(a_pready, i_clk, i_rst_n, pready, "pready low")

endmodule

bind wheel_tachometer_weighted_average tach_chk u_tach_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_rpm_q8       (o_rpm_q8),
    .o_sample_taken (o_sample_taken),
    .pready         (pready)
);
